>>> rtl/core/sfcv_pkg.sv
// Shared types, constants and AES/CMAC helper functions for the secured
// frame CMAC verifier. No dependencies.
package sfcv_pkg;

   localparam int unsigned NUM_ROUNDS = 10;
   localparam logic [6:0] MIN_FRAME_LEN = 7'd14;

   // register indexes of the control port
   localparam logic [1:0] REG_KEY_HIGH      = 2'd0;
   localparam logic [1:0] REG_KEY_LOW       = 2'd1;
   localparam logic [1:0] REG_DATA_ID       = 2'd2;
   localparam logic [1:0] REG_COMMIT_ENABLE = 2'd3;

   localparam logic [63:0] KEY_HIGH_RESET = 64'h0001020304050607;
   localparam logic [63:0] KEY_LOW_RESET  = 64'h08090a0b0c0d0e0f;
   localparam logic [15:0] DATA_ID_RESET  = 16'h1234;

   // verdict codes
   localparam logic [1:0] VERDICT_SHORT    = 2'd0;
   localparam logic [1:0] VERDICT_MISMATCH = 2'd1;
   localparam logic [1:0] VERDICT_ACCEPT   = 2'd2;

   // side data that travels with a block through the rounds
   typedef struct packed {
      logic [28:0] frame_id;
      logic        is_short;
      logic [15:0] freshness;
      logic [31:0] mac_tag;
   } meta_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] v;
      case (r)
         4'd1:    v = 8'h01;
         4'd2:    v = 8'h02;
         4'd3:    v = 8'h04;
         4'd4:    v = 8'h08;
         4'd5:    v = 8'h10;
         4'd6:    v = 8'h20;
         4'd7:    v = 8'h40;
         4'd8:    v = 8'h80;
         4'd9:    v = 8'h1b;
         4'd10:   v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // next AES-128 round key from the previous one
   function automatic logic [127:0] key_next(input logic [127:0] w, input logic [7:0] rc);
      logic [31:0] t;
      logic [31:0] n0, n1, n2, n3;
      t  = {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
      n0 = w[127:96] ^ t;
      n1 = w[95:64] ^ n0;
      n2 = w[63:32] ^ n1;
      n3 = w[31:0] ^ n2;
      return {n0, n1, n2, n3};
   endfunction

   // one AES round; byte i sits at bits [127-8i -: 8], i = row + 4*column
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
      logic [7:0] t [16];
      logic [7:0] m [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] o;
      for (int i = 0; i < 16; i++) begin
         t[i] = SBOX[s[127 - 8 * ((i % 4) + 4 * (((i / 4) + (i % 4)) % 4)) -: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4 * c];
         a1 = t[4 * c + 1];
         a2 = t[4 * c + 2];
         a3 = t[4 * c + 3];
         all = a0 ^ a1 ^ a2 ^ a3;
         m[4 * c]     = last ? a0 : a0 ^ all ^ xtime(a0 ^ a1);
         m[4 * c + 1] = last ? a1 : a1 ^ all ^ xtime(a1 ^ a2);
         m[4 * c + 2] = last ? a2 : a2 ^ all ^ xtime(a2 ^ a3);
         m[4 * c + 3] = last ? a3 : a3 ^ all ^ xtime(a3 ^ a0);
      end
      for (int i = 0; i < 16; i++) begin
         o[127 - 8 * i -: 8] = m[i];
      end
      return o ^ rk;
   endfunction

   // doubling in GF(2^128)
   function automatic logic [127:0] gf_dbl(input logic [127:0] b);
      return {b[126:0], 1'b0} ^ (b[127] ? 128'h87 : 128'h0);
   endfunction

endpackage

>>> rtl/core/sfcv_ifs.sv
// Valid/ready channel interfaces for the frame and verdict beats.
// Depends on nothing.
interface sfcv_req_if;
   logic        valid;
   logic        ready;
   logic [28:0] frame_id;
   logic [6:0]  frame_len;
   logic [63:0] payload;
   logic [15:0] freshness_low;
   logic [31:0] mac_tag;
   modport source (output valid, frame_id, frame_len, payload, freshness_low, mac_tag,
                   input ready);
   modport sink (input valid, frame_id, frame_len, payload, freshness_low, mac_tag,
                 output ready);
endinterface

interface sfcv_rsp_if;
   logic        valid;
   logic        ready;
   logic [28:0] frame_id_out;
   logic [15:0] freshness_value;
   logic [1:0]  verdict;
   logic        commit;
   modport source (output valid, frame_id_out, freshness_value, verdict, commit, input ready);
   modport sink (input valid, frame_id_out, freshness_value, verdict, commit, output ready);
endinterface

>>> rtl/core/secured_frame_cmac_verify.sv
// Top level of the secured frame CMAC verifier: register port, input stage,
// round stages and verdict stage. Depends on sfcv_pkg, sfcv_ifs, sfcv_stage, sfcv_keysched.
//
// Usage:
//   req_bus carries one received frame per beat (identifier, length, payload,
//   truncated freshness, truncated MAC); rsp_bus returns exactly one verdict
//   beat per frame, in order. Both use valid/ready.
//   csr_we/csr_index/csr_wdata write the key halves, data id and commit
//   enable; writes are expected only while no frame is in flight.
// Pipeline: input stage, ten AES round stages and verdict stage, each one
//   registered. Throughput: one frame per cycle while rsp_bus is not stalled
//   and the keys are ready, set by the fully unrolled round stages.
// Reset and writes: after reset and after every register write the key
//   table and subkey K2 are rebuilt by a sequencer, one step per cycle
//   (load, key expansion, zero-block encryption); req_bus.ready stays low during that time.
// Stall: each full stage holds while the stage after it is full and blocked, so
//   bubbles close up and nothing is dropped or repeated while rsp is stalled.
module secured_frame_cmac_verify (
   input  logic             clock,
   input  logic             reset,
   sfcv_req_if.sink         req_bus,
   sfcv_rsp_if.source       rsp_bus,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_wdata
);
   logic [63:0]  key_high_ff, key_low_ff;
   logic [15:0]  data_id_ff;
   logic         commit_en_ff;

   logic [127:0] round_keys [11];
   logic [127:0] subkey2;
   logic         keys_ready;

   logic         v [11];
   logic [127:0] st [11];
   sfcv_pkg::meta_type mt [11];
   logic         adv [12];

   logic         req_fire;
   logic [127:0] blk_in;
   sfcv_pkg::meta_type meta_in;

   logic         out_v_ff;
   logic [28:0]  out_id_ff;
   logic [15:0]  out_fresh_ff;
   logic [1:0]   out_verdict_ff, verdict_in;
   logic         out_commit_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff  <= sfcv_pkg::KEY_HIGH_RESET;
         key_low_ff   <= sfcv_pkg::KEY_LOW_RESET;
         data_id_ff   <= sfcv_pkg::DATA_ID_RESET;
         commit_en_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            sfcv_pkg::REG_KEY_HIGH:      key_high_ff  <= csr_wdata;
            sfcv_pkg::REG_KEY_LOW:       key_low_ff   <= csr_wdata;
            sfcv_pkg::REG_DATA_ID:       data_id_ff   <= csr_wdata[15:0];
            sfcv_pkg::REG_COMMIT_ENABLE: commit_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   sfcv_keysched u_keysched (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_we),
      .key        ({key_high_ff, key_low_ff}),
      .round_keys (round_keys),
      .subkey2    (subkey2),
      .keys_ready (keys_ready)
   );

   // stall chain: a stage moves when empty or when its successor moves
   always_comb begin
      adv[11] = !out_v_ff || rsp_bus.ready;
      for (int k = 10; k >= 0; k--) begin
         adv[k] = !v[k] || adv[k + 1];
      end
   end

   assign req_bus.ready = adv[0] && keys_ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // input stage: padded block, K2 and round key 0 whitening
   assign blk_in = {data_id_ff, 16'h0000, req_bus.freshness_low, req_bus.payload,
                    8'h80, 8'h00} ^ subkey2 ^ round_keys[0];
   assign meta_in = '{frame_id:  req_bus.frame_id,
                      is_short:  (req_bus.frame_len < sfcv_pkg::MIN_FRAME_LEN),
                      freshness: req_bus.freshness_low,
                      mac_tag:   req_bus.mac_tag};

   always_ff @(posedge clock) begin
      if (reset) begin
         v[0] <= 1'b0;
      end else if (adv[0]) begin
         v[0] <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         st[0] <= blk_in;
         mt[0] <= meta_in;
      end
   end

   // round stages
   for (genvar r = 1; r <= 10; r++) begin : g_round
      sfcv_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv[r]),
         .last      (r == 10),
         .round_key (round_keys[r]),
         .valid_in  (v[r - 1]),
         .state_in  (st[r - 1]),
         .meta_in   (mt[r - 1]),
         .valid_out (v[r]),
         .state_out (st[r]),
         .meta_out  (mt[r])
      );
   end

   // verdict stage
   always_comb begin
      if (mt[10].is_short) begin
         verdict_in = sfcv_pkg::VERDICT_SHORT;
      end else if (st[10][127:96] == mt[10].mac_tag) begin
         verdict_in = sfcv_pkg::VERDICT_ACCEPT;
      end else begin
         verdict_in = sfcv_pkg::VERDICT_MISMATCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv[11]) begin
         out_v_ff <= v[10];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[11]) begin
         out_id_ff      <= mt[10].frame_id;
         out_fresh_ff   <= mt[10].is_short ? 16'h0000 : mt[10].freshness;
         out_verdict_ff <= verdict_in;
         out_commit_ff  <= (verdict_in == sfcv_pkg::VERDICT_ACCEPT) && commit_en_ff;
      end
   end

   assign rsp_bus.valid           = out_v_ff;
   assign rsp_bus.frame_id_out    = out_id_ff;
   assign rsp_bus.freshness_value = out_fresh_ff;
   assign rsp_bus.verdict         = out_verdict_ff;
   assign rsp_bus.commit          = out_commit_ff;

   // commit only on an accepted frame
   a_commit_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.commit |-> rsp_bus.verdict == sfcv_pkg::VERDICT_ACCEPT)
      else $error("commit without accept");
   // short frames report zero freshness
   a_short_fresh: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.verdict == sfcv_pkg::VERDICT_SHORT
      |-> rsp_bus.freshness_value == 16'h0000) else $error("short frame freshness");
   // no frame enters while the keys are being rebuilt
   a_no_accept_rebuild: assert property (@(posedge clock) disable iff (reset)
      !keys_ready |=> !v[0]) else $error("frame entered during key rebuild");
   // a full last round stage behind a blocked output keeps its frame
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      v[10] && !adv[11] |=> v[10]) else $error("frame lost in stall");
endmodule

>>> rtl/core/sfcv_stage.sv
// One registered AES round stage of the verify pipeline.
// Depends on sfcv_pkg.
module sfcv_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              last,
   input  logic [127:0]      round_key,
   input  logic              valid_in,
   input  logic [127:0]      state_in,
   input  sfcv_pkg::meta_type meta_in,
   output logic              valid_out,
   output logic [127:0]      state_out,
   output sfcv_pkg::meta_type meta_out
);
   logic              valid_ff;
   logic [127:0]      state_ff, state_in_c;
   sfcv_pkg::meta_type meta_ff;

   assign state_in_c = sfcv_pkg::aes_round(state_in, round_key, last);

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         state_ff <= state_in_c;
         meta_ff  <= meta_in;
      end
   end

   assign valid_out = valid_ff;
   assign state_out = state_ff;
   assign meta_out  = meta_ff;
endmodule

>>> rtl/core/sfcv_keysched.sv
// Round key table and CMAC subkey K2, rebuilt after reset and each register write.
// Depends on sfcv_pkg.
module sfcv_keysched (
   input  logic         clock,
   input  logic         reset,
   input  logic         restart,
   input  logic [127:0] key,
   output logic [127:0] round_keys [11],
   output logic [127:0] subkey2,
   output logic         keys_ready
);
   typedef enum logic [3:0] {
      ST_LOAD   = 4'b0001,
      ST_EXPAND = 4'b0010,
      ST_SUBKEY = 4'b0100,
      ST_DONE   = 4'b1000
   } ks_state_type;

   ks_state_type state_ff, state_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic [127:0] cur_ff, next_key;
   logic [127:0] blk_ff;
   logic [127:0] rk_ff [11];
   logic         cnt_last;

   assign next_key = sfcv_pkg::key_next(cur_ff, sfcv_pkg::rcon(cnt_ff));
   assign cnt_last = (cnt_ff == 4'(sfcv_pkg::NUM_ROUNDS));

   // sequencer: load, expand ten round keys, encrypt the zero block
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_LOAD: begin
            state_in = ST_EXPAND;
            cnt_in   = 4'd1;
         end
         ST_EXPAND: begin
            cnt_in = cnt_last ? 4'd1 : cnt_ff + 4'd1;
            if (cnt_last) state_in = ST_SUBKEY;
         end
         ST_SUBKEY: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_last) state_in = ST_DONE;
         end
         ST_DONE:  state_in = ST_DONE;
         default:  state_in = ST_LOAD;
      endcase
      if (restart) state_in = ST_LOAD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= 4'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // key table and zero-block encryption
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_LOAD: begin
            rk_ff[0] <= key;
            cur_ff   <= key;
         end
         ST_EXPAND: begin
            rk_ff[cnt_ff] <= next_key;
            cur_ff        <= next_key;
            blk_ff        <= rk_ff[0];
         end
         ST_SUBKEY: blk_ff <= sfcv_pkg::aes_round(blk_ff, rk_ff[cnt_ff], cnt_last);
         default: ;
      endcase
   end

   assign round_keys = rk_ff;
   assign subkey2    = sfcv_pkg::gf_dbl(sfcv_pkg::gf_dbl(blk_ff));
   assign keys_ready = (state_ff == ST_DONE);

   // a write always withdraws the keys for the rebuild
   a_restart_drops: assert property (@(posedge clock) disable iff (reset)
      restart |=> !keys_ready) else $error("keys ready right after restart");
   // the rebuild starts from the load step
   a_restart_load: assert property (@(posedge clock) disable iff (reset)
      restart |=> state_ff == ST_LOAD) else $error("restart did not reload key");
   // keys come ready only at the end of the subkey pass
   a_ready_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(keys_ready) |-> $past(state_ff) == ST_SUBKEY) else $error("early keys");
endmodule
